>>> rtl/core/dense_layer_train_engine_defines.svh
// Assertion macros for the RTL file that carries checks.
`ifndef DENSE_LAYER_TRAIN_ENGINE_DEFINES_SVH
`define DENSE_LAYER_TRAIN_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DLTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DLTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dlte_pkg.sv
`default_nettype none
package dlte_pkg;

  localparam int unsigned MAX_INPUTS_DEF  = 1024;
  localparam int unsigned MAX_OUTPUTS_DEF = 16;
  localparam int unsigned RESULT_CAP      = 16;

  localparam int unsigned ACC_W  = 40;
  localparam int unsigned MUL_AW = 24;
  localparam int unsigned MUL_BW = 17;
  localparam int unsigned PROD_W = MUL_AW + MUL_BW;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] GRAD_LIM = 41'sd6553600;
  localparam logic signed [18:0] WEIGHT_LIM = 19'sd2560;

  localparam logic [10:0] INPUT_COUNT_RST  = 11'd1024;
  localparam logic [4:0]  OUTPUT_COUNT_RST = 5'd10;
  localparam logic [15:0] LEARN_RATE_RST   = 16'd655;

  typedef enum logic [2:0] {
    ACT_WR_WEIGHT = 3'd0,
    ACT_WR_BIAS   = 3'd1,
    ACT_FORWARD   = 3'd2,
    ACT_GRAD      = 3'd3,
    ACT_READ      = 3'd4
  } dlte_act_e;

  typedef enum logic [1:0] {
    CFG_INPUT_COUNT  = 2'd0,
    CFG_OUTPUT_COUNT = 2'd1,
    CFG_LEARN_RATE   = 2'd2
  } dlte_cfg_e;

  localparam logic KIND_LOGIT = 1'b0;
  localparam logic KIND_GRAD  = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         row_index;
    logic [9:0]         col_index;
    logic signed [15:0] data_value;
    logic               last_element;
  } dlte_in_t;

  typedef struct packed {
    logic               result_kind;
    logic [9:0]         result_index;
    logic signed [15:0] result_value;
    logic               result_last;
  } dlte_out_t;

  // Saturating accumulate of a product into a 40-bit accumulator.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] s;
    s = (PROD_W+1)'(a) + (PROD_W+1)'(p);
    if (s > (PROD_W+1)'(ACC_MAX)) begin
      return ACC_MAX;
    end else if (s < (PROD_W+1)'(ACC_MIN)) begin
      return ACC_MIN;
    end
    return ACC_W'(s);
  endfunction

  // Accumulator to Q8.8: floor shift by eight, then saturate.
  function automatic logic signed [15:0] q88_out(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] s;
    s = acc >>> 8;
    if (s > 40'sd32767) begin
      return 16'sh7fff;
    end else if (s < -40'sd32768) begin
      return 16'sh8000;
    end
    return 16'(s);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/dense_layer_train_engine.sv
// Each item is decoded first. A forward element multiplies its input by the weight of each
// active output in turn and accumulates, and on the last element one logit beat per output
// follows. A gradient row updates each active weight, then the bias; row 0 also clears the rest.
// Throughput is one item at a time, set by the single shared multiplier and weight port.
// Reset is asynchronous, active low: biases, logits and counters clear, weights and inputs
// are undefined until written; the receiver cannot stall result beats.
`default_nettype none
`include "dense_layer_train_engine_defines.svh"
module dense_layer_train_engine #(
  parameter int unsigned MAX_INPUTS  = dlte_pkg::MAX_INPUTS_DEF,
  parameter int unsigned MAX_OUTPUTS = dlte_pkg::MAX_OUTPUTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire dlte_pkg::dlte_in_t item_i,
  output logic                    result_valid_o,
  output dlte_pkg::dlte_out_t     result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);
  import dlte_pkg::*;

  // Address widths of the stores and widths of the counters.
  localparam int unsigned IAW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned OAW      = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int unsigned CW       = $clog2(MAX_INPUTS + 1);
  localparam int unsigned NOUT_MAX = (MAX_OUTPUTS < RESULT_CAP) ? MAX_OUTPUTS : RESULT_CAP;
  localparam int unsigned OCW      = $clog2(NOUT_MAX + 1);
  localparam int unsigned WAW      = OAW + IAW;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE,
    S_F_RD, S_F_MUL, S_F_ACC, S_EMIT,
    S_G_RD, S_G_M1, S_G_M2, S_G_M3, S_G_M4,
    S_B1, S_B2, S_R_OUT
  } state_e;

  // Configuration registers; write them only while the engine is idle (the block does not enforce it).
  logic [10:0] in_cnt_q;
  logic [4:0]  out_cnt_q;
  logic [15:0] lr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= INPUT_COUNT_RST;
      out_cnt_q <= OUTPUT_COUNT_RST;
      lr_q      <= LEARN_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INPUT_COUNT:  in_cnt_q  <= cfg_data_i[10:0];
        CFG_OUTPUT_COUNT: out_cnt_q <= cfg_data_i[4:0];
        CFG_LEARN_RATE:   lr_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Active sizes: the input count is clamped to 1..MAX_INPUTS, the output count to
  // 1..min(MAX_OUTPUTS, 16).
  logic [CW-1:0]  nin;
  logic [OCW-1:0] nout;

  always_comb begin
    if (in_cnt_q == '0) begin
      nin = CW'(1);
    end else if (32'(in_cnt_q) > MAX_INPUTS) begin
      nin = CW'(MAX_INPUTS);
    end else begin
      nin = CW'(in_cnt_q);
    end
    if (out_cnt_q == '0) begin
      nout = OCW'(1);
    end else if (32'(out_cnt_q) > NOUT_MAX) begin
      nout = OCW'(NOUT_MAX);
    end else begin
      nout = OCW'(out_cnt_q);
    end
  end

  // Sequencer state. The item is held in item_q for its whole run; pos_q is the position in
  // the current forward run and grow_q the row of the current gradient pass.
  state_e                  state_q;
  dlte_in_t                item_q;
  logic [CW-1:0]           pos_q;
  logic [4:0]              grow_q;
  logic                    grad_ok_q;
  logic [OAW-1:0]          oi_q;
  logic [CW-1:0]           j_q;
  logic signed [15:0]      bias_q  [MAX_OUTPUTS];
  logic signed [ACC_W-1:0] logit_q [MAX_OUTPUTS];
  logic                    res_valid_q;
  dlte_out_t               res_q;

  logic accept;
  assign accept = start && !busy;

  // Decoded fields of the held item.
  logic [31:0]    row32, col32, r32;
  logic           row_ok, col_ok, row_live, oi_last, row0, j_in;
  logic [OAW-1:0] row_idx, r_idx;
  logic [IAW-1:0] col_idx, j_idx, pos_idx;
  logic [CW-1:0]  j_lim;

  assign row32    = 32'(item_q.row_index);
  assign col32    = 32'(item_q.col_index);
  assign r32      = 32'(grow_q);
  assign row_ok   = row32 < MAX_OUTPUTS;
  assign col_ok   = col32 < MAX_INPUTS;
  assign row_idx  = row32[OAW-1:0];
  assign col_idx  = col32[IAW-1:0];
  assign r_idx    = r32[OAW-1:0];
  assign row_live = r32 < 32'(nout);
  assign row0     = (grow_q == '0);
  assign oi_last  = (32'(oi_q) == 32'(nout) - 32'd1);
  assign j_idx    = j_q[IAW-1:0];
  assign pos_idx  = pos_q[IAW-1:0];
  assign j_in     = j_q < nin;
  // Row 0 sweeps the whole gradient store so that entries beyond the active inputs clear.
  assign j_lim    = row0 ? CW'(MAX_INPUTS) : nin;

  // Store ports and the shared multiplier.
  logic                     w_we, w_re, i_we, i_re, g_we, g_re, mul_en;
  logic [WAW-1:0]           w_waddr, w_raddr;
  logic [15:0]              w_wdata, w_rdata, i_rdata;
  logic [IAW-1:0]           i_addr, g_waddr, g_raddr;
  logic [ACC_W-1:0]         g_wdata, g_rdata;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  // Update terms that follow the registered product.
  logic signed [PROD_W-1:0] sh_w, sh_b;
  logic signed [18:0]       nw;
  logic signed [17:0]       nb;
  logic signed [15:0]       w_new, b_new;
  logic signed [MUL_AW-1:0] gp;
  logic signed [ACC_W-1:0]  g_base;

  always_comb begin
    sh_w = prod >>> 24;
    sh_b = prod >>> 16;
    nw   = 19'($signed(w_rdata)) - $signed(sh_w[18:0]);
    nb   = 18'(bias_q[r_idx]) - $signed(sh_b[17:0]);
    if (nw > WEIGHT_LIM) begin
      w_new = 16'(WEIGHT_LIM);
    end else if (nw < -WEIGHT_LIM) begin
      w_new = 16'(-WEIGHT_LIM);
    end else begin
      w_new = 16'(nw);
    end
    if (nb > 18'sd32767) begin
      b_new = 16'sh7fff;
    end else if (nb < -18'sd32768) begin
      b_new = 16'sh8000;
    end else begin
      b_new = 16'(nb);
    end
    // The clipped g*x gradient term, in Q16.16.
    if (prod > GRAD_LIM) begin
      gp = MUL_AW'(GRAD_LIM);
    end else if (prod < -GRAD_LIM) begin
      gp = MUL_AW'(-GRAD_LIM);
    end else begin
      gp = MUL_AW'(prod);
    end
    g_base = row0 ? '0 : $signed(g_rdata);
  end

  always_comb begin
    w_we    = 1'b0;
    w_waddr = '0;
    w_wdata = '0;
    w_re    = 1'b0;
    w_raddr = '0;
    i_we    = 1'b0;
    i_re    = 1'b0;
    i_addr  = '0;
    g_we    = 1'b0;
    g_waddr = '0;
    g_wdata = '0;
    g_re    = 1'b0;
    g_raddr = '0;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      S_DECODE: begin
        case (item_q.action)
          ACT_WR_WEIGHT: begin
            w_we    = row_ok && col_ok;
            w_waddr = {row_idx, col_idx};
            w_wdata = item_q.data_value;
          end
          ACT_FORWARD: begin
            i_we   = pos_q < nin;
            i_addr = pos_idx;
          end
          ACT_READ: begin
            g_re    = col_ok;
            g_raddr = col_idx;
          end
          default: ;
        endcase
      end
      S_F_RD: begin
        w_re    = 1'b1;
        w_raddr = {oi_q, pos_idx};
      end
      S_F_MUL, S_G_M1: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(item_q.data_value);
        mul_b  = MUL_BW'($signed(w_rdata));
      end
      S_G_RD: begin
        w_re    = j_in;
        w_raddr = {r_idx, j_idx};
        i_re    = j_in;
        i_addr  = j_idx;
        g_re    = j_in;
        g_raddr = j_idx;
        g_we    = !j_in;
        g_waddr = j_idx;
      end
      S_G_M2: begin
        g_we    = 1'b1;
        g_waddr = j_idx;
        g_wdata = sat_acc(g_base, prod);
        mul_en  = 1'b1;
        mul_a   = MUL_AW'(item_q.data_value);
        mul_b   = MUL_BW'($signed(i_rdata));
      end
      S_G_M3: begin
        mul_en = 1'b1;
        mul_a  = gp;
        mul_b  = $signed({1'b0, lr_q});
      end
      S_G_M4: begin
        w_we    = 1'b1;
        w_waddr = {r_idx, j_idx};
        w_wdata = w_new;
      end
      S_B1: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(item_q.data_value);
        mul_b  = $signed({1'b0, lr_q});
      end
      default: ;
    endcase
  end

  // Forward inputs are written from the held item in the decode cycle.
  dlte_ram #(.W(16), .AW(WAW)) u_wmem (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  dlte_ram #(.W(16), .AW(IAW)) u_imem (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_addr),
    .wdata_i (item_q.data_value),
    .re_i    (i_re),
    .raddr_i (i_addr),
    .rdata_o (i_rdata)
  );

  dlte_ram #(.W(ACC_W), .AW(IAW)) u_gmem (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .re_i    (g_re),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  dlte_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Main sequencer. Result beats are registered and shown for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      pos_q       <= '0;
      grow_q      <= '0;
      grad_ok_q   <= 1'b0;
      oi_q        <= '0;
      j_q         <= '0;
      bias_q      <= '{default: '0};
      logit_q     <= '{default: '0};
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            item_q  <= item_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_q <= S_IDLE;
          case (item_q.action)
            ACT_WR_BIAS: begin
              if (row_ok) begin
                bias_q[row_idx] <= item_q.data_value;
              end
            end
            ACT_FORWARD: begin
              // A new run seeds every logit with its bias in Q.16.
              if (pos_q == '0) begin
                for (int k = 0; k < MAX_OUTPUTS; k++) begin
                  logit_q[k] <= ACC_W'(bias_q[k]) <<< 8;
                end
              end
              oi_q <= '0;
              if (pos_q < nin) begin
                state_q <= S_F_RD;
              end else if (item_q.last_element) begin
                pos_q   <= '0;
                state_q <= S_EMIT;
              end
            end
            ACT_GRAD: begin
              j_q <= '0;
              if (row0) begin
                grad_ok_q <= 1'b1;
                state_q   <= S_G_RD;
              end else if (row_live) begin
                state_q <= S_G_RD;
              end else if (item_q.last_element) begin
                grow_q <= '0;
              end else if (grow_q != 5'd31) begin
                grow_q <= grow_q + 5'd1;
              end
            end
            ACT_READ: begin
              if (col_ok && grad_ok_q) begin
                state_q <= S_R_OUT;
              end else begin
                res_valid_q        <= 1'b1;
                res_q.result_kind  <= KIND_GRAD;
                res_q.result_index <= item_q.col_index;
                res_q.result_value <= '0;
                res_q.result_last  <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_F_RD:  state_q <= S_F_MUL;
        S_F_MUL: state_q <= S_F_ACC;
        S_F_ACC: begin
          logit_q[oi_q] <= sat_acc(logit_q[oi_q], prod);
          if (oi_last) begin
            oi_q <= '0;
            if (item_q.last_element) begin
              pos_q   <= '0;
              state_q <= S_EMIT;
            end else begin
              pos_q   <= pos_q + CW'(1);
              state_q <= S_IDLE;
            end
          end else begin
            oi_q    <= oi_q + OAW'(1);
            state_q <= S_F_RD;
          end
        end
        S_EMIT: begin
          res_valid_q        <= 1'b1;
          res_q.result_kind  <= KIND_LOGIT;
          res_q.result_index <= 10'(oi_q);
          res_q.result_value <= q88_out(logit_q[oi_q]);
          res_q.result_last  <= oi_last;
          if (oi_last) begin
            state_q <= S_IDLE;
          end else begin
            oi_q <= oi_q + OAW'(1);
          end
        end
        S_G_RD: begin
          if (j_in) begin
            state_q <= S_G_M1;
          end else if (j_q == j_lim - CW'(1)) begin
            state_q <= S_B1;
          end else begin
            j_q <= j_q + CW'(1);
          end
        end
        S_G_M1: state_q <= S_G_M2;
        S_G_M2: state_q <= S_G_M3;
        S_G_M3: state_q <= S_G_M4;
        S_G_M4: begin
          if (j_q == j_lim - CW'(1)) begin
            state_q <= S_B1;
          end else begin
            j_q     <= j_q + CW'(1);
            state_q <= S_G_RD;
          end
        end
        S_B1: state_q <= S_B2;
        S_B2: begin
          bias_q[r_idx] <= b_new;
          if (item_q.last_element) begin
            grow_q <= '0;
          end else if (grow_q != 5'd31) begin
            grow_q <= grow_q + 5'd1;
          end
          state_q <= S_IDLE;
        end
        S_R_OUT: begin
          res_valid_q        <= 1'b1;
          res_q.result_kind  <= KIND_GRAD;
          res_q.result_index <= item_q.col_index;
          res_q.result_value <= q88_out($signed(g_rdata));
          res_q.result_last  <= 1'b1;
          state_q            <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // An accepted item always occupies the engine for at least the decode cycle.
  `DLTE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not make engine busy")
  // Logit beats only name output neurons below NOUT_MAX.
  `DLTE_ASSERT_IMP(a_logit_index, result_valid_o && (result_o.result_kind == KIND_LOGIT), result_o.result_index < 10'(NOUT_MAX), "logit index out of range")
  // Every gradient read answers with a single, final beat.
  `DLTE_ASSERT_IMP(a_read_last, result_valid_o && (result_o.result_kind == KIND_GRAD), result_o.result_last, "gradient read beat not marked last")

endmodule
`default_nettype wire

>>> rtl/core/dlte_ram.sv
`default_nettype none
module dlte_ram #(
  parameter int unsigned W  = 16,
  parameter int unsigned AW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [2**AW];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/dlte_mul.sv
`default_nettype none
module dlte_mul (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic signed [dlte_pkg::MUL_AW-1:0]   a_i,
  input  wire logic signed [dlte_pkg::MUL_BW-1:0]   b_i,
  output logic signed      [dlte_pkg::PROD_W-1:0]   prod_o
);
  import dlte_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // Registered product; it holds while the unit is not enabled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire
